// File: rtl/prm_pkg.sv
// shared types and constants for the polynomial resultant unit
// no dependencies; imported by every module of the block
`default_nettype none

package prm_pkg;

  localparam int MAX_LEN   = 256;
  localparam int COEF_BITS = 64;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int CNT_W     = $clog2(COEF_BITS);
  localparam int NBANK     = 3;

  typedef struct packed {
    logic                 mode;
    logic [COEF_BITS-1:0] coeff;
    logic                 last;
    logic                 empty_poly;
  } in_t;

  typedef struct packed {
    logic [COEF_BITS-1:0] resultant;
    logic                 overflow;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                 phase;
    logic                 empty;
    logic                 last;
    logic [COEF_BITS-1:0] coeff;
  } cmd_t;

  typedef struct packed {
    logic                 go;
    logic [COEF_BITS-1:0] a;
    logic [COEF_BITS-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic [COEF_BITS-1:0] val;
  } mul_rsp_t;

  typedef struct packed {
    logic                 go;
    logic [COEF_BITS-1:0] num;
    logic [COEF_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [COEF_BITS-1:0] quo;
    logic [COEF_BITS-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/prm_front.sv
// front end: filters requests by polynomial phase and queues them
// depends on prm_pkg
`default_nettype none

module prm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire prm_pkg::in_t  item,
  output logic               item_stall,
  output logic               cmd_valid,
  output prm_pkg::cmd_t      cmd,
  input  wire logic          cmd_pop
);
  import prm_pkg::*;

  logic       phase;
  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       acc;
  logic       push;
  logic       pop;

  assign item_stall = (count == 2'd2);
  assign acc        = item_valid && !item_stall;
  // a request for the polynomial not being loaded is dropped
  assign push       = acc && (item.mode == phase);
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = q[rp];
  assign pop        = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        q[wp] <= '{phase: phase, empty: item.empty_poly, last: item.last,
                   coeff: item.coeff};
        wp    <= ~wp;
        if (item.last || item.empty_poly) begin
          phase <= ~phase;
        end
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/prm_div.sv
// restoring divider, one quotient bit per cycle
// depends on prm_pkg
`default_nettype none

module prm_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire prm_pkg::div_req_t req,
  output prm_pkg::div_rsp_t      rsp
);
  import prm_pkg::*;

  logic [COEF_BITS-1:0] quo;
  logic [COEF_BITS:0]   rem;
  logic [COEF_BITS-1:0] den;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;
  logic [COEF_BITS:0]   trial;

  assign trial    = {rem[COEF_BITS-1:0], quo[COEF_BITS-1]};
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem[COEF_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
        cnt  <= CNT_W'(COEF_BITS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[COEF_BITS-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[COEF_BITS-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/prm_mul.sv
// modular multiplier, double-and-add over the multiplier bits, a doubling step then an add step per bit
// depends on prm_pkg
`default_nettype none

module prm_mul (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [prm_pkg::COEF_BITS-1:0]  n,
  input  wire prm_pkg::mul_req_t              req,
  output prm_pkg::mul_rsp_t                   rsp
);
  import prm_pkg::*;

  logic [COEF_BITS-1:0] a;
  logic [COEF_BITS-1:0] b;
  logic [COEF_BITS-1:0] r;
  logic [CNT_W-1:0]     cnt;
  logic                 half;
  logic                 busy;
  logic                 done;

  function automatic logic [COEF_BITS-1:0] add_m(input logic [COEF_BITS-1:0] x,
                                                 input logic [COEF_BITS-1:0] y,
                                                 input logic [COEF_BITS-1:0] m);
    logic [COEF_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[COEF_BITS-1:0];
  endfunction

  assign rsp.done = done;
  assign rsp.val  = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        a    <= req.a;
        b    <= req.b;
        r    <= '0;
        cnt  <= CNT_W'(COEF_BITS - 1);
        half <= 1'b0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!half) begin
          r    <= add_m(r, r, n);
          half <= 1'b1;
        end else begin
          if (b[cnt]) begin
            r <= add_m(r, a, n);
          end
          half <= 1'b0;
          if (cnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/prm_back.sv
// back end: coefficient stores, remainder sequence sequencer, result register
// depends on prm_pkg; drives prm_mul and prm_div
`default_nettype none

module prm_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           modulus_we,
  input  wire logic [prm_pkg::COEF_BITS-1:0]  modulus_wdata,
  output logic      [prm_pkg::COEF_BITS-1:0]  n,
  input  wire logic                           cmd_valid,
  input  wire prm_pkg::cmd_t                  cmd,
  output logic                                cmd_pop,
  output prm_pkg::mul_req_t                   mul_req,
  input  wire prm_pkg::mul_rsp_t              mul_rsp,
  output prm_pkg::div_req_t                   div_req,
  input  wire prm_pkg::div_rsp_t              div_rsp,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output prm_pkg::out_t                       result
);
  import prm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_RED, S_WRITE, S_AFTER, S_START, S_STRIP_RD, S_STRIP_CHK,
    S_STRIP2, S_CHECK, S_DISPATCH, S_CONST, S_CONST_DONE, S_ITER, S_LC, S_INV,
    S_INV_DIV, S_INV_MUL, S_PR_OUTER, S_PR_Q, S_PR_QW, S_PR_RD, S_PR_M, S_PR_MW,
    S_CP_RD, S_CP_WR, S_ROT, S_RES, S_RES_MUL, S_RES_MW, S_FLIP, S_OUT,
    S_POW, S_POW_M1, S_POW_SQ, S_POW_SW
  } state_t;

  typedef enum logic [1:0] {ROLE_U, ROLE_V, ROLE_R} role_t;

  state_t st;
  state_t pow_ret;
  state_t strip_ret;

  logic [COEF_BITS-1:0] res, lc, iv, q, tmp, wval, pw_r, pw_b, r0, r1, t0, t1;
  logic [LEN_W-1:0]     len1, len2, l0, l1, l2, sl, i, j, pw_e;
  logic                 ovf, flip;
  role_t                sr;
  logic [1:0]           pu, pv, pr;
  cmd_t                 c;
  logic [LEN_W-1:0]     cl;

  logic [COEF_BITS-1:0] mem [NBANK][MAX_LEN];
  logic [COEF_BITS-1:0] rd [NBANK];
  logic [ADDR_W-1:0]    ra [NBANK];
  logic [ADDR_W-1:0]    ra_u, ra_v, ra_r, wa;
  logic                 we;
  role_t                wrole;
  logic [1:0]           wbank;
  logic [COEF_BITS-1:0] wd;
  logic [COEF_BITS-1:0] rd_u, rd_v, rd_s;
  logic [LEN_W-1:0]     sl_m1, l2_m1, i_m1, pr_idx;
  logic [COEF_BITS-1:0] quo_m;

  function automatic logic [COEF_BITS-1:0] sub_m(input logic [COEF_BITS-1:0] x,
                                                 input logic [COEF_BITS-1:0] y,
                                                 input logic [COEF_BITS-1:0] m);
    logic [COEF_BITS-1:0] d;
    d = x - y;
    if (x < y) begin
      d = d + m;
    end
    return d;
  endfunction

  function automatic logic [COEF_BITS-1:0] neg_m(input logic [COEF_BITS-1:0] x,
                                                 input logic [COEF_BITS-1:0] m);
    return (x == '0) ? '0 : m - x;
  endfunction

  assign cl      = c.phase ? len2 : len1;
  assign sl_m1   = sl - 1'b1;
  assign l2_m1   = l2 - 1'b1;
  assign i_m1    = i - 1'b1;
  assign pr_idx  = i - l1 + j;
  assign rd_u    = rd[pu];
  assign rd_v    = rd[pv];
  assign rd_s    = (sr == ROLE_U) ? rd[pu] : (sr == ROLE_V) ? rd[pv] : rd[pr];
  // quotient is at most n here, so one subtract reduces it
  assign quo_m   = (div_rsp.quo >= n) ? div_rsp.quo - n : div_rsp.quo;
  assign cmd_pop = (st == S_IDLE) && cmd_valid;

  always_comb begin
    ra_u  = '0;
    ra_v  = '0;
    ra_r  = '0;
    we    = 1'b0;
    wrole = ROLE_U;
    wa    = '0;
    wd    = '0;
    case (st)
      S_WRITE: begin
        we    = 1'b1;
        wrole = c.phase ? ROLE_V : ROLE_U;
        wa    = cl[ADDR_W-1:0];
        wd    = wval;
      end
      S_STRIP_RD: begin
        ra_u = sl_m1[ADDR_W-1:0];
        ra_v = sl_m1[ADDR_W-1:0];
        ra_r = sl_m1[ADDR_W-1:0];
      end
      S_DISPATCH: ra_v = '0;
      S_ITER:     ra_v = l2_m1[ADDR_W-1:0];
      S_PR_OUTER: ra_u = i_m1[ADDR_W-1:0];
      S_PR_RD: begin
        ra_u = pr_idx[ADDR_W-1:0];
        ra_v = j[ADDR_W-1:0];
      end
      S_PR_MW: begin
        we    = mul_rsp.done;
        wrole = ROLE_U;
        wa    = pr_idx[ADDR_W-1:0];
        wd    = sub_m(tmp, mul_rsp.val, n);
      end
      S_CP_RD: ra_u = j[ADDR_W-1:0];
      S_CP_WR: begin
        we    = 1'b1;
        wrole = ROLE_R;
        wa    = j[ADDR_W-1:0];
        wd    = rd_u;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (wrole)
      ROLE_U:  wbank = pu;
      ROLE_V:  wbank = pv;
      default: wbank = pr;
    endcase
    for (int k = 0; k < NBANK; k++) begin
      if (pu == 2'(k)) begin
        ra[k] = ra_u;
      end else if (pv == 2'(k)) begin
        ra[k] = ra_v;
      end else begin
        ra[k] = ra_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NBANK; k++) begin
      if (we && wbank == 2'(k)) begin
        mem[k][wa] <= wd;
      end
      rd[k] <= mem[k][ra[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      n            <= COEF_BITS'(2);
      len1         <= '0;
      len2         <= '0;
      ovf          <= 1'b0;
      pu           <= 2'd0;
      pv           <= 2'd1;
      pr           <= 2'd2;
      result_valid <= 1'b0;
      mul_req.go   <= 1'b0;
      div_req.go   <= 1'b0;
    end else begin
      mul_req.go <= 1'b0;
      div_req.go <= 1'b0;
      if (modulus_we) begin
        n <= modulus_wdata;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (cmd_valid) begin
            c  <= cmd;
            st <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (c.empty) begin
            if (c.phase) begin
              len2 <= '0;
            end else begin
              len1 <= '0;
            end
            st <= S_AFTER;
          end else if (cl >= LEN_W'(MAX_LEN)) begin
            ovf <= 1'b1;
            st  <= S_AFTER;
          end else if (n < COEF_BITS'(2)) begin
            wval <= '0;
            st   <= S_WRITE;
          end else if (c.coeff < n) begin
            wval <= c.coeff;
            st   <= S_WRITE;
          end else begin
            div_req <= '{go: 1'b1, num: c.coeff, den: n};
            st      <= S_RED;
          end
        end
        S_RED: begin
          if (div_rsp.done) begin
            wval <= div_rsp.rem;
            st   <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (c.phase) begin
            len2 <= len2 + 1'b1;
          end else begin
            len1 <= len1 + 1'b1;
          end
          st <= S_AFTER;
        end
        S_AFTER: begin
          st <= ((c.last || c.empty) && c.phase) ? S_START : S_IDLE;
        end
        S_START: begin
          if (ovf || n < COEF_BITS'(2)) begin
            res  <= '0;
            flip <= 1'b0;
            st   <= S_FLIP;
          end else begin
            sl        <= len1;
            sr        <= ROLE_U;
            strip_ret <= S_STRIP2;
            st        <= S_STRIP_RD;
          end
        end
        // drop zero leading coefficients of the store in role sr
        S_STRIP_RD: begin
          st <= (sl == '0) ? strip_ret : S_STRIP_CHK;
        end
        S_STRIP_CHK: begin
          if (rd_s == '0) begin
            sl <= sl_m1;
            st <= S_STRIP_RD;
          end else begin
            st <= strip_ret;
          end
        end
        S_STRIP2: begin
          len1      <= sl;
          sl        <= len2;
          sr        <= ROLE_V;
          strip_ret <= S_CHECK;
          st        <= S_STRIP_RD;
        end
        S_CHECK: begin
          if (len1 == '0 || sl == '0) begin
            res  <= '0;
            flip <= 1'b0;
            st   <= S_FLIP;
          end else begin
            if (len1 < sl) begin
              pu   <= pv;
              pv   <= pu;
              len1 <= sl;
              len2 <= len1;
              flip <= ~(len1[0] | sl[0]);
            end else begin
              len2 <= sl;
              flip <= 1'b0;
            end
            st <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (len2 == LEN_W'(1)) begin
            st <= S_CONST;
          end else begin
            res <= COEF_BITS'(1);
            l1  <= len1;
            l2  <= len2;
            st  <= S_ITER;
          end
        end
        // second operand is a constant: its power is the answer
        S_CONST: begin
          pw_b    <= rd_v;
          pw_r    <= COEF_BITS'(1);
          pw_e    <= len1 - 1'b1;
          pow_ret <= S_CONST_DONE;
          st      <= S_POW;
        end
        S_CONST_DONE: begin
          res <= pw_r;
          st  <= S_FLIP;
        end
        S_ITER: begin
          l0 <= l1;
          l1 <= l2;
          st <= S_LC;
        end
        S_LC: begin
          lc <= rd_v;
          if (l1 >= LEN_W'(2)) begin
            r0 <= n;
            r1 <= rd_v;
            t0 <= '0;
            t1 <= COEF_BITS'(1);
            st <= S_INV;
          end else begin
            sl <= '0;
            st <= S_ROT;
          end
        end
        // extended euclid for the divisor's leading coefficient
        S_INV: begin
          if (r1 == '0) begin
            iv <= t0;
            i  <= l0;
            st <= S_PR_OUTER;
          end else begin
            div_req <= '{go: 1'b1, num: r0, den: r1};
            st      <= S_INV_DIV;
          end
        end
        S_INV_DIV: begin
          if (div_rsp.done) begin
            tmp     <= div_rsp.rem;
            mul_req <= '{go: 1'b1, a: quo_m, b: t1};
            st      <= S_INV_MUL;
          end
        end
        S_INV_MUL: begin
          if (mul_rsp.done) begin
            t1 <= sub_m(t0, mul_rsp.val, n);
            t0 <= t1;
            r0 <= r1;
            r1 <= tmp;
            st <= S_INV;
          end
        end
        S_PR_OUTER: begin
          if (i < l1) begin
            j  <= '0;
            st <= S_CP_RD;
          end else begin
            st <= S_PR_Q;
          end
        end
        S_PR_Q: begin
          mul_req <= '{go: 1'b1, a: rd_u, b: iv};
          st      <= S_PR_QW;
        end
        S_PR_QW: begin
          if (mul_rsp.done) begin
            q  <= mul_rsp.val;
            j  <= '0;
            st <= S_PR_RD;
          end
        end
        S_PR_RD: begin
          if (j == l1) begin
            i  <= i_m1;
            st <= S_PR_OUTER;
          end else begin
            st <= S_PR_M;
          end
        end
        S_PR_M: begin
          tmp     <= rd_u;
          mul_req <= '{go: 1'b1, a: q, b: rd_v};
          st      <= S_PR_MW;
        end
        S_PR_MW: begin
          if (mul_rsp.done) begin
            j  <= j + 1'b1;
            st <= S_PR_RD;
          end
        end
        // copy the low part of the reduced dividend out as the remainder
        S_CP_RD: begin
          if (j + 1'b1 >= l1) begin
            sl        <= l1 - 1'b1;
            sr        <= ROLE_R;
            strip_ret <= S_ROT;
            st        <= S_STRIP_RD;
          end else begin
            st <= S_CP_WR;
          end
        end
        S_CP_WR: begin
          j  <= j + 1'b1;
          st <= S_CP_RD;
        end
        S_ROT: begin
          l2 <= sl;
          pu <= pv;
          pv <= pr;
          pr <= pu;
          st <= S_RES;
        end
        S_RES: begin
          if (l2 != '0 || l1 == LEN_W'(1)) begin
            pw_b    <= lc;
            pw_r    <= COEF_BITS'(1);
            pw_e    <= (l2 != '0) ? l0 - l2 : l0 - 1'b1;
            pow_ret <= S_RES_MUL;
            st      <= S_POW;
          end else begin
            res <= '0;
            st  <= S_FLIP;
          end
        end
        S_RES_MUL: begin
          mul_req <= '{go: 1'b1, a: res, b: pw_r};
          st      <= S_RES_MW;
        end
        S_RES_MW: begin
          if (mul_rsp.done) begin
            if (l2 != '0 && !(l0[0] | l1[0])) begin
              res <= neg_m(mul_rsp.val, n);
            end else begin
              res <= mul_rsp.val;
            end
            st <= (l2 != '0) ? S_ITER : S_FLIP;
          end
        end
        S_FLIP: begin
          if (flip) begin
            res <= neg_m(res, n);
          end
          st <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result       <= '{resultant: res, overflow: ovf};
            result_valid <= 1'b1;
            len1         <= '0;
            len2         <= '0;
            ovf          <= 1'b0;
            pu           <= 2'd0;
            pv           <= 2'd1;
            pr           <= 2'd2;
            st           <= S_IDLE;
          end
        end
        // square and multiply, pw_r holds the running power
        S_POW: begin
          if (pw_e == '0) begin
            st <= pow_ret;
          end else if (pw_e[0]) begin
            mul_req <= '{go: 1'b1, a: pw_r, b: pw_b};
            st      <= S_POW_M1;
          end else begin
            st <= S_POW_SQ;
          end
        end
        S_POW_M1: begin
          if (mul_rsp.done) begin
            pw_r <= mul_rsp.val;
            st   <= S_POW_SQ;
          end
        end
        S_POW_SQ: begin
          mul_req <= '{go: 1'b1, a: pw_b, b: pw_b};
          st      <= S_POW_SW;
        end
        S_POW_SW: begin
          if (mul_rsp.done) begin
            pw_b <= mul_rsp.val;
            pw_e <= pw_e >> 1;
            st   <= S_POW;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/poly_resultant_mod_p_euclid_unit.sv
// resultant of two polynomials modulo n by the euclidean remainder sequence
// top level; depends on prm_pkg, prm_front, prm_back, prm_mul, prm_div
//
// usage: write the modulus through modulus_we/modulus_wdata while idle (reset
// value 2). send requests on item/item_valid, taken when item_stall is low:
// all coefficients of f lowest first, then those of g, last marking the
// leading one, empty_poly standing for a zero polynomial. requests whose mode
// is not the polynomial being loaded are taken and dropped.
// the request that ends g produces one result on result/result_valid, held
// stable while result_stall is high.
// back end: a coefficient already below the modulus is written straight to its
// store, one needing reduction goes through the bit-serial divider first. a two-entry
// queue lets the front keep taking requests meanwhile.
// work per result: the remainder sequence needs on the order of len_f * len_g
// modular products plus one extended-euclid inverse per division step, each
// round of which is a division and a product.
// reset clears lengths, phase, queue and the result valid flag; store contents
// are not cleared and need no clearing pass.

`default_nettype none

module poly_resultant_mod_p_euclid_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           modulus_we,
  input  wire logic [prm_pkg::COEF_BITS-1:0]  modulus_wdata,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire prm_pkg::in_t                   item,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output prm_pkg::out_t                       result
);
  import prm_pkg::*;

  logic                 cmd_valid;
  cmd_t                 cmd;
  logic                 cmd_pop;
  logic [COEF_BITS-1:0] n;
  mul_req_t             mul_req;
  mul_rsp_t             mul_rsp;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  prm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  prm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .modulus_we    (modulus_we),
    .modulus_wdata (modulus_wdata),
    .n             (n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .mul_req       (mul_req),
    .mul_rsp       (mul_rsp),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  prm_mul u_mul (
    .clk (clk),
    .rst (rst),
    .n   (n),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  prm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

`default_nettype wire

// File: verif/resultant_checker.sv
// checker for poly_resultant_mod_p_euclid_unit: watches both channels and the modulus port,
// predicts each resultant and compares it with what the block returns
// depends on prm_pkg
`default_nettype none

module resultant_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          modulus_we,
  input  wire logic [prm_pkg::COEF_BITS-1:0] modulus_wdata,
  input  wire logic                          item_valid,
  input  wire logic                          item_stall,
  input  wire prm_pkg::in_t                  item,
  input  wire logic                          result_valid,
  input  wire logic                          result_stall,
  input  wire prm_pkg::out_t                 result,
  output int                                 mismatches,
  output int                                 pending,
  output int                                 requests_seen,
  output int                                 results_seen,
  output int                                 overflows_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import prm_pkg::*;

  typedef logic [COEF_BITS-1:0] word_t;

  word_t  modulus;
  word_t  banks [3][MAX_LEN];   // 0 holds f, 1 holds g, 2 is scratch
  int     len_f, len_g;
  logic   loading_g;
  logic   ovf_sticky;
  out_t   expected_results[$];

  assign pending = expected_results.size();

  function automatic word_t add_mod(word_t a, word_t b, word_t n);
    logic [COEF_BITS:0] s;
    s = a + b;
    if (s >= n) s = s - n;
    return s[COEF_BITS-1:0];
  endfunction

  function automatic word_t sub_mod(word_t a, word_t b, word_t n);
    return (a >= b) ? a - b : a - b + n;
  endfunction

  function automatic word_t neg_mod(word_t a, word_t n);
    return (a == 0) ? '0 : n - a;
  endfunction

  function automatic word_t mul_mod(word_t a, word_t b, word_t n);
    logic [2*COEF_BITS-1:0] p;
    p = a * b;
    p = p % n;
    return p[COEF_BITS-1:0];
  endfunction

  function automatic word_t pow_mod(word_t b, word_t e, word_t n);
    word_t r;
    r = 1 % n;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b, n);
      b = mul_mod(b, b, n);
      e = e >> 1;
    end
    return r;
  endfunction

  // extended euclid; on a composite modulus the leftover value is kept as is
  function automatic word_t inv_mod(word_t a, word_t n);
    word_t r0, r1, t0, t1, q, nr, nt;
    r0 = n; r1 = a; t0 = '0; t1 = 1 % n;
    while (r1 != 0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      nt = sub_mod(t0, mul_mod(q % n, t1, n), n);
      r0 = r1; r1 = nr;
      t0 = t1; t1 = nt;
    end
    return t0;
  endfunction

  // remainder of bank a (length la) by bank b (length lb) into bank dst
  function automatic void reduce_by(int dst, int a, int la, int b, int lb, word_t n);
    word_t iv, q;
    int    base;
    iv = inv_mod(banks[b][lb-1], n);
    for (int i = la; i >= lb; i--) begin
      q = mul_mod(banks[a][i-1], iv, n);
      base = i - lb;
      for (int j = 0; j < lb; j++)
        banks[a][base+j] = sub_mod(banks[a][base+j], mul_mod(q, banks[b][j], n), n);
    end
    for (int j = 0; j + 1 < lb; j++)
      banks[dst][j] = banks[a][j];
  endfunction

  function automatic word_t euclid_resultant();
    word_t n, res, lc;
    int    u, v, r, t, l0, l1, l2, la, lb;
    logic  flip;
    n = modulus; u = 0; v = 1; r = 2;
    la = len_f; lb = len_g; flip = 1'b0;
    if (n < 2) return '0;
    while (la > 0 && banks[u][la-1] == 0) la--;
    while (lb > 0 && banks[v][lb-1] == 0) lb--;
    if (la == 0 || lb == 0) return '0;
    if (la < lb) begin
      t = u; u = v; v = t;
      l0 = la; la = lb; lb = l0;
      flip = ((la | lb) & 1) == 0;
    end
    if (lb == 1) begin
      res = pow_mod(banks[v][0], word_t'(la - 1), n);
    end else begin
      res = 1 % n;
      l1 = la; l2 = lb;
      do begin
        l0 = l1;
        l1 = l2;
        lc = banks[v][l1-1];
        if (l1 >= 2) reduce_by(r, u, l0, v, l1, n);
        l2 = l1 - 1;
        while (l2 > 0 && banks[r][l2-1] == 0) l2--;
        t = u; u = v; v = r; r = t;
        if (l2 >= 1) begin
          res = mul_mod(res, pow_mod(lc, word_t'(l0 - l2), n), n);
          if (((l0 | l1) & 1) == 0) res = neg_mod(res, n);
        end else if (l1 == 1) begin
          res = mul_mod(res, pow_mod(lc, word_t'(l0 - 1), n), n);
        end else begin
          res = '0;
        end
      end while (l2 > 0);
    end
    if (flip) res = neg_mod(res, n);
    return res;
  endfunction

  function automatic void take_request(in_t req);
    logic ends_poly;
    int   bank;
    out_t exp_res;
    ends_poly = req.last;
    bank = loading_g ? 1 : 0;
    if (req.mode != loading_g) return;   // wrong polynomial: dropped
    if (req.empty_poly) begin
      if (loading_g) len_g = 0; else len_f = 0;
      ends_poly = 1'b1;
    end else if ((loading_g ? len_g : len_f) >= MAX_LEN) begin
      ovf_sticky = 1'b1;
    end else if (loading_g) begin
      banks[1][len_g] = (modulus >= 2) ? req.coeff % modulus : '0;
      len_g++;
    end else begin
      banks[0][len_f] = (modulus >= 2) ? req.coeff % modulus : '0;
      len_f++;
    end
    if (!ends_poly) return;
    if (!loading_g) begin
      loading_g = 1'b1;
      return;
    end
    exp_res.resultant = ovf_sticky ? '0 : euclid_resultant();
    exp_res.overflow  = ovf_sticky;
    expected_results.push_back(exp_res);
    len_f = 0; len_g = 0; loading_g = 1'b0; ovf_sticky = 1'b0;
  endfunction

  always @(posedge clk) begin
    out_t exp_res;
    if (rst) begin
      modulus = word_t'(2); len_f = 0; len_g = 0; loading_g = 1'b0; ovf_sticky = 1'b0;
    end else begin
      if (modulus_we) modulus = modulus_wdata;
      if (item_valid && !item_stall) begin
        requests_seen++;
        take_request(item);
      end
      if (result_valid && !result_stall) begin
        results_seen++;
        if (result.overflow) overflows_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: resultant %h overflow %b",
                     result.resultant, result.overflow);
        end else begin
          exp_res = expected_results.pop_front();
          if (result.resultant !== exp_res.resultant || result.overflow !== exp_res.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: resultant exp %h got %h, overflow exp %b got %b",
                       exp_res.resultant, result.resultant, exp_res.overflow,
                       result.overflow);
          end
        end
      end
    end
  end

  initial begin
    mismatches = 0; requests_seen = 0; results_seen = 0; overflows_seen = 0;
  end

endmodule

`default_nettype wire

// File: verif/tb.sv
// top of the poly_resultant_mod_p_euclid_unit testbench: clock, reset, request and
// modulus stimulus, result stall, verdict; depends on prm_pkg and resultant_checker
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prm_pkg::*;

  typedef logic [COEF_BITS-1:0] word_t;
  localparam logic MODE_F = 1'b0;
  localparam logic MODE_G = 1'b1;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  modulus_we = 1'b0;
  word_t modulus_wdata = '0;
  logic  item_valid = 1'b0;
  logic  item_stall;
  in_t   item = '0;
  logic  result_valid;
  logic  result_stall = 1'b0;
  out_t  result;

  int    mismatches, pending, requests_seen, results_seen, overflows_seen;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_left = 0;
  logic  hold_start = 1'b0;
  logic  hold_done = 1'b0;
  word_t cur_mod = 2;

  always #5 clk = ~clk;

  poly_resultant_mod_p_euclid_unit DUT (
    .clk, .rst, .modulus_we, .modulus_wdata, .item_valid, .item_stall, .item,
    .result_valid, .result_stall, .result
  );

  resultant_checker checker_i (
    .clk, .rst, .modulus_we, .modulus_wdata, .item_valid, .item_stall, .item,
    .result_valid, .result_stall, .result, .mismatches, .pending, .requests_seen,
    .results_seen, .overflows_seen
  );

  // result side: long hold-off when asked, otherwise random stall
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_start && !hold_done) begin
      result_stall <= 1'b1;
      hold_left <= 2999;
      hold_done <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_req(logic mode, word_t coeff, logic last, logic empty);
    in_t req;
    req.mode = mode; req.coeff = coeff; req.last = last; req.empty_poly = empty;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= req;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_poly(logic mode, word_t coeffs[$]);
    foreach (coeffs[i]) send_req(mode, coeffs[i], i == coeffs.size() - 1, 1'b0);
  endtask

  function automatic word_t rand_coeff();
    word_t c;
    c = {$urandom, $urandom};
    if ($urandom_range(3) != 0 && cur_mod >= 2) c = c % cur_mod;
    return c;
  endfunction

  task automatic send_random_poly(logic mode, int len);
    word_t cs[$];
    word_t lead;
    for (int i = 0; i < len; i++) cs.push_back(rand_coeff());
    lead = cs[len-1];
    if (cur_mod >= 2 && lead % cur_mod == 0 && $urandom_range(3) != 0) cs[len-1] = 1;
    send_poly(mode, cs);
  endtask

  function automatic int rand_len();
    return ($urandom_range(19) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
  endfunction

  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);   // let the back end finish any trailing coefficient
  endtask

  task automatic write_modulus(word_t m);
    modulus_we <= 1'b1;
    modulus_wdata <= m;
    cur_mod = m;
    @(posedge clk);
    modulus_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_pairs(int n_req);
    int start;
    start = requests_seen;
    while (requests_seen - start < n_req) begin
      case ($urandom_range(9))
        0: send_req(~checker_i.loading_g, {$urandom, $urandom}, 1'($urandom_range(1)),
                    1'b0);
        1: begin
          send_req(MODE_F, '0, 1'b0, 1'b1);
          send_random_poly(MODE_G, rand_len());
        end
        2: begin
          send_random_poly(MODE_F, rand_len());
          send_req(MODE_G, {$urandom, $urandom}, 1'b0, 1'b0);
          send_req(MODE_G, {$urandom, $urandom}, 1'($urandom_range(1)), 1'b1);
          if (!item.empty_poly) send_req(MODE_G, '0, 1'b0, 1'b1);
        end
        default: begin
          send_random_poly(MODE_F, rand_len());
          send_random_poly(MODE_G, rand_len());
        end
      endcase
    end
  endtask

  initial begin
    word_t mods[6];
    word_t q[$];
    mods = '{64'd7, 64'd65521, 64'd15, 64'hFFFF_FFFF_FFFF_FFC5, 64'd1,
             64'hFFFF_FFFF_FFFF_FFFF};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset modulus of two
    send_poly(MODE_F, '{1, 0, 1});
    send_poly(MODE_G, '{1, 1});
    settle();

    write_modulus(7);
    send_poly(MODE_F, '{3, 5});                      // g constant
    send_poly(MODE_G, '{4});
    send_poly(MODE_F, '{1, 2});                      // f shorter, both even: swap
    send_poly(MODE_G, '{6, 0, 2, 1});
    send_poly(MODE_F, '{2, 4, 1});                   // common factor x-1: zero
    send_poly(MODE_G, '{6, 1});
    send_req(MODE_F, '0, 1'b0, 1'b1);                // empty f
    send_poly(MODE_G, '{1, 1});
    send_poly(MODE_F, '{1, 1});                      // empty g after coefficients
    send_req(MODE_G, 5, 1'b0, 1'b0);
    send_req(MODE_G, '0, 1'b0, 1'b1);
    send_req(MODE_G, 3, 1'b1, 1'b0);                 // wrong polynomial, dropped
    send_poly(MODE_F, '{64'hFFFF_FFFF_FFFF_FFFF, 3, 0, 0});  // trailing zeros
    send_req(MODE_F, 1, 1'b1, 1'b0);                 // wrong polynomial, dropped
    send_poly(MODE_G, '{0, 0, 7});                   // all zero mod 7
    settle();

    // more coefficients than fit
    q = {};
    for (int i = 0; i < MAX_LEN + 2; i++) q.push_back(i + 1);
    send_poly(MODE_F, q);
    send_poly(MODE_G, '{2, 3});
    settle();

    foreach (mods[p]) begin
      write_modulus(mods[p]);
      case (p % 3)
        0: begin send_idle_pct = 22; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (p == 2) hold_start <= 1'b1;
      random_pairs(75);
      settle();
    end

    $display("%0d requests sent over 7 moduli, %0d resultants checked (%0d overflowed)",
             requests_seen, results_seen, overflows_seen);
    if (mismatches == 0)
      $display("poly_resultant_mod_p_euclid_unit test passed");
    else
      $display("poly_resultant_mod_p_euclid_unit test failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("poly_resultant_mod_p_euclid_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
